>>> hw/rtl/cpm_pkg.sv
// shared widths, opcodes, status codes and register map of the control patch memory
`timescale 1ns / 1ps
`default_nettype none
package cpm_pkg;

  localparam int unsigned StoreDepth = 1024;

  localparam int unsigned DataW   = 32;
  localparam int unsigned IdxW    = 16;
  localparam int unsigned CfgW    = 10;
  localparam int unsigned OpW     = 2;
  localparam int unsigned StatusW = 2;

  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [OpW-1:0] OpRead     = 2'd0;
  localparam logic [OpW-1:0] OpWrite    = 2'd1;
  localparam logic [OpW-1:0] OpModulate = 2'd2;
  localparam logic [OpW-1:0] OpClear    = 2'd3;

  localparam logic [StatusW-1:0] StsOk    = 2'd0;
  localparam logic [StatusW-1:0] StsAbove = 2'd1;
  localparam logic [StatusW-1:0] StsNeg   = 2'd2;
  localparam logic [StatusW-1:0] StsOrder = 2'd3;

  // register index, taken from the word address
  localparam logic RegLastValidIndex = 1'b0;

  localparam logic [CfgW-1:0] LastValidIndexRst = 10'd1023;

  localparam logic signed [DataW-1:0] DataMax = 32'sh7fff_ffff;
  localparam logic signed [DataW-1:0] DataMin = 32'sh8000_0000;

endpackage
`default_nettype wire

>>> hw/rtl/cpm_if.sv
// request and response channel interfaces of the control patch memory
`timescale 1ns / 1ps
`default_nettype none
interface cpm_req_if import cpm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OpW-1:0]          opcode;
  logic signed [IdxW-1:0]  index;
  logic signed [IdxW-1:0]  range_end;
  logic signed [DataW-1:0] value;
  logic                    mix;

  modport source (output valid, opcode, index, range_end, value, mix, input ready);
  modport sink   (input valid, opcode, index, range_end, value, mix, output ready);
endinterface

interface cpm_rsp_if import cpm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] result;
  logic [StatusW-1:0]      status;

  modport source (output valid, result, status, input ready);
  modport sink   (input valid, result, status, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/cpm_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module cpm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                             wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                                  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> hw/rtl/control_patch_memory_core.sv
// control patch memory: q16.16 store with read, write/mix, modulate and range clear
// sequence: read, write and modulate add pass through SRead to SDone, a multiply adds SMul,
//   a rejected request or a modulate at index zero goes straight to SDone, clear steps SClear
// throughput: one request at a time; the store ram gives one read and one write per cycle
// reset: after rst_ni the store is zeroed one entry per cycle
//   and no request is taken meanwhile; configuration writes are taken throughout
`timescale 1ns / 1ps
`default_nettype none
module control_patch_memory_core import cpm_pkg::*; #(
  parameter int unsigned STORE_DEPTH = StoreDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0]      prdata,
  output logic                     pready,
  cpm_req_if.sink                  req_i,
  cpm_rsp_if.source                rsp_o
);

  localparam int unsigned AddrW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned ExtW  = IdxW + 1;
  localparam logic signed [ExtW-1:0] DepthMax = ExtW'(STORE_DEPTH - 1);
  localparam logic [AddrW-1:0]       LastAddr = AddrW'(STORE_DEPTH - 1);

  localparam logic [2:0] SInit  = 3'd0;
  localparam logic [2:0] SIdle  = 3'd1;
  localparam logic [2:0] SRead  = 3'd2;
  localparam logic [2:0] SMul   = 3'd3;
  localparam logic [2:0] SClear = 3'd4;
  localparam logic [2:0] SDone  = 3'd5;

  logic [2:0]                state_q, state_d;
  logic [AddrW-1:0]          ptr_q, ptr_d;
  logic [AddrW-1:0]          end_q, end_d;
  logic [CfgW-1:0]           lvi_q;
  logic                      ovalid_q, ovalid_d;
  logic signed [DataW-1:0]   ores_q, ores_d;
  logic [StatusW-1:0]        osts_q, osts_d;
  logic signed [DataW-1:0]   res_q, res_d;
  logic [StatusW-1:0]        sts_q, sts_d;
  logic [OpW-1:0]            op_q, op_d;
  logic signed [DataW-1:0]   val_q, val_d;
  logic                      mix_q, mix_d;
  logic                      neg_q, neg_d;
  logic signed [2*DataW-1:0] prod_q, prod_d;

  logic                      cfg_wr;
  logic                      acc;
  logic signed [ExtW-1:0]    lvi_ext, lim, idx_x, end_x, abs_x;
  logic [StatusW-1:0]        chk_sts;

  logic                      ram_we;
  logic [AddrW-1:0]          ram_waddr;
  logic [DataW-1:0]          ram_wdata;
  logic [DataW-1:0]          ram_rdata;
  logic signed [DataW-1:0]   rd_s;

  logic signed [DataW:0]     sum;
  logic signed [DataW-1:0]   sat_sum;
  logic signed [DataW-1:0]   mul_res;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegLastValidIndex);
  assign prdata = (paddr[2] == RegLastValidIndex) ? ApbDataW'(lvi_q) : '0;

  // request checks
  assign acc     = req_i.valid && req_i.ready;
  assign lvi_ext = ExtW'(lvi_q);
  assign lim     = (lvi_ext < DepthMax) ? lvi_ext : DepthMax;
  assign idx_x   = ExtW'(req_i.index);
  assign end_x   = ExtW'(req_i.range_end);
  assign abs_x   = idx_x[ExtW-1] ? -idx_x : idx_x;

  always_comb begin
    chk_sts = StsOk;
    case (req_i.opcode)
      OpRead, OpWrite: begin
        if (idx_x > lim) chk_sts = StsAbove;
        else if (idx_x[ExtW-1]) chk_sts = StsNeg;
      end
      OpModulate: begin
        if (abs_x > lim) chk_sts = StsAbove;
      end
      OpClear: begin
        if (idx_x > lim || end_x > lim) chk_sts = StsAbove;
        else if (idx_x[ExtW-1] || end_x[ExtW-1]) chk_sts = StsNeg;
        else if (idx_x > end_x) chk_sts = StsOrder;
      end
      default: chk_sts = StsOk;
    endcase
  end

  // shared arithmetic: saturating add and q16.16 multiply
  assign rd_s    = ram_rdata;
  assign sum     = (DataW + 1)'(val_q) + (DataW + 1)'(rd_s);
  assign sat_sum = (sum[DataW] != sum[DataW-1]) ? (sum[DataW] ? DataMin : DataMax)
                                                : sum[DataW-1:0];
  assign mul_res = (prod_q[2*DataW-1:DataW+15] == '0 || prod_q[2*DataW-1:DataW+15] == '1)
                   ? prod_q[DataW+15:16]
                   : (prod_q[2*DataW-1] ? DataMin : DataMax);

  // sequencer
  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    end_d     = end_q;
    ovalid_d  = ovalid_q;
    ores_d    = ores_q;
    osts_d    = osts_q;
    res_d     = res_q;
    sts_d     = sts_q;
    op_d      = op_q;
    val_d     = val_q;
    mix_d     = mix_q;
    neg_d     = neg_q;
    prod_d    = prod_q;
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = '0;

    if (rsp_o.valid && rsp_o.ready) ovalid_d = 1'b0;

    case (state_q)
      SInit: begin
        ram_we = 1'b1;
        ptr_d  = ptr_q + AddrW'(1);
        if (ptr_q == LastAddr) state_d = SIdle;
      end
      SIdle: begin
        if (acc) begin
          op_d  = req_i.opcode;
          val_d = req_i.value;
          mix_d = req_i.mix;
          neg_d = req_i.index[IdxW-1];
          sts_d = chk_sts;
          res_d = '0;
          ptr_d = abs_x[AddrW-1:0];
          end_d = end_x[AddrW-1:0];
          if (chk_sts != StsOk) begin
            state_d = SDone;
          end else if (req_i.opcode == OpClear) begin
            state_d = SClear;
          end else if (req_i.opcode == OpModulate && req_i.index == '0) begin
            res_d   = req_i.value;
            state_d = SDone;
          end else begin
            state_d = SRead;
          end
        end
      end
      SRead: begin
        case (op_q)
          OpRead: begin
            res_d   = rd_s;
            state_d = SDone;
          end
          OpWrite: begin
            ram_we    = 1'b1;
            ram_wdata = mix_q ? sat_sum : val_q;
            state_d   = SDone;
          end
          OpModulate: begin
            if (neg_q) begin
              prod_d  = (2*DataW)'(val_q) * (2*DataW)'(rd_s);
              state_d = SMul;
            end else begin
              res_d   = sat_sum;
              state_d = SDone;
            end
          end
          default: state_d = SDone;
        endcase
      end
      SMul: begin
        res_d   = mul_res;
        state_d = SDone;
      end
      SClear: begin
        ram_we = 1'b1;
        ptr_d  = ptr_q + AddrW'(1);
        if (ptr_q == end_q) state_d = SDone;
      end
      SDone: begin
        if (!ovalid_q || rsp_o.ready) begin
          ovalid_d = 1'b1;
          ores_d   = res_q;
          osts_d   = sts_q;
          state_d  = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SInit;
      ptr_q    <= '0;
      ovalid_q <= 1'b0;
      lvi_q    <= LastValidIndexRst;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      ovalid_q <= ovalid_d;
      if (cfg_wr) lvi_q <= pwdata[CfgW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    end_q  <= end_d;
    ores_q <= ores_d;
    osts_q <= osts_d;
    res_q  <= res_d;
    sts_q  <= sts_d;
    op_q   <= op_d;
    val_q  <= val_d;
    mix_q  <= mix_d;
    neg_q  <= neg_d;
    prod_q <= prod_d;
  end

  cpm_ram #(
    .WIDTH (DataW),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (abs_x[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready  = (state_q == SIdle);
  assign rsp_o.valid  = ovalid_q;
  assign rsp_o.result = ores_q;
  assign rsp_o.status = osts_q;

endmodule
`default_nettype wire
